[src/biquad_cascade_lowpass_to_drive_macros.svh]
// shared assertion macros
`ifndef BIQUAD_CASCADE_LOWPASS_TO_DRIVE_MACROS_SVH
`define BIQUAD_CASCADE_LOWPASS_TO_DRIVE_MACROS_SVH
// a condition implies another at the same edge
`define BQ_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a condition implies another by non-overlapping implication
`define BQ_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[src/bqcas_pkg.sv]
// ----------------------------------------------------------------------------
// bqcas_pkg
// shared types and constants of the biquad cascade
// ----------------------------------------------------------------------------
package bqcas_pkg;
    localparam int SIG_W  = 48;
    localparam int COEF_W = 32;
    localparam int ACC_W  = 84;
    localparam int DIG_W  = 4;
    localparam int MUL_STEPS = SIG_W / DIG_W;
    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = 10;
    localparam logic [0:0] REG_ENABLE = 1'b0;
    localparam logic [0:0] REG_BASE   = 1'b1;

    typedef logic signed [SIG_W-1:0]  sig_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic start;
        logic clear;
    } mac_ctl_t;

    function automatic coef_t coef(input logic [1:0] row, input logic [1:0] col);
        coef_t c;
        c = '0;
        case ({row, col})
            4'h0: c = 32'sd58652;
            4'h1: c = 32'sd2146040194;
            4'h2: c = -32'sd1072561603;
            4'h4: c = 32'sd47848;
            4'h5: c = 32'sd2143934624;
            4'h6: c = -32'sd1070384191;
            4'h8: c = 32'sd22524;
            4'h9: c = 32'sd2142372280;
            4'hA: c = -32'sd1068720552;
            4'hC: c = 32'sd4641;
            4'hD: c = 32'sd2141544477;
            4'hE: c = -32'sd1067821218;
            default: c = '0;
        endcase
        return c;
    endfunction
endpackage

[src/bqcas_mac.sv]
// ----------------------------------------------------------------------------
// bqcas_mac
// digit-serial multiply-accumulate, four multiplicand bits per cycle
// ----------------------------------------------------------------------------
module bqcas_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  bqcas_pkg::mac_ctl_t ctl,
    input  bqcas_pkg::sig_t    mcand,
    input  bqcas_pkg::coef_t   coef_in,
    output logic               busy,
    output bqcas_pkg::acc_t    acc
);
    localparam int CW = $clog2(bqcas_pkg::MUL_STEPS + 1);
    localparam int PW = bqcas_pkg::COEF_W + bqcas_pkg::DIG_W + 1;

    bqcas_pkg::sig_t  shf_reg;
    bqcas_pkg::coef_t c_reg;
    bqcas_pkg::acc_t  term_reg;
    bqcas_pkg::acc_t  sum_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    logic signed [bqcas_pkg::DIG_W:0] dig;
    logic signed [PW-1:0]             part;

    // msb first: the first digit taken is the signed top digit
    always_comb
    begin
        if (cnt_reg == CW'(bqcas_pkg::MUL_STEPS))
            dig = {shf_reg[bqcas_pkg::SIG_W-1], shf_reg[bqcas_pkg::SIG_W-1 -: bqcas_pkg::DIG_W]};
        else
            dig = {1'b0, shf_reg[bqcas_pkg::SIG_W-1 -: bqcas_pkg::DIG_W]};
        part = PW'(dig) * PW'(c_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            shf_reg  <= '0;
            c_reg    <= '0;
            term_reg <= '0;
            done_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (ctl.start)
            begin
                cnt_reg  <= CW'(bqcas_pkg::MUL_STEPS);
                shf_reg  <= mcand;
                c_reg    <= coef_in;
                term_reg <= '0;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - CW'(1);
                shf_reg  <= shf_reg << bqcas_pkg::DIG_W;
                // shift the running product of this term, add the new digit
                term_reg <= (term_reg <<< bqcas_pkg::DIG_W) + bqcas_pkg::acc_t'(part);
            end
            if (ctl.clear)
                sum_reg <= '0;
            else if (done_reg)
                sum_reg <= sum_reg + term_reg;
        end
    end

    assign busy = (cnt_reg != '0) || done_reg;
    assign acc  = sum_reg;
endmodule

[src/bqcas_div44.sv]
// ----------------------------------------------------------------------------
// bqcas_div44
// maps a 16-bit code to code/44 + 88 by reciprocal multiply
// ----------------------------------------------------------------------------
module bqcas_div44 (
    input  logic        clk,
    input  logic [15:0] u,
    output logic [10:0] drive
);
    logic [26:0] prod_reg;
    logic [15:0] u_reg;
    logic [10:0] q;
    logic [15:0] r;

    always_ff @(posedge clk)
    begin
        prod_reg <= 27'(u) * 27'd1489;   // 2^16/44 rounded down
        u_reg    <= u;
    end

    always_comb
    begin
        q = prod_reg[26:16];
        r = u_reg - 16'(q) * 16'd44;
        if (r >= 16'd44)
            q = q + 11'd1;
        drive = q + 11'd88;
    end
endmodule

[src/biquad_cascade_lowpass_to_drive.sv]
// ----------------------------------------------------------------------------
// biquad_cascade_lowpass_to_drive
// four-section df1 low-pass cascade turning audio samples into drive codes
// ----------------------------------------------------------------------------
// One sample word is taken at a time, and its result word is presented
// only after the whole cascade has run: each section runs three products
// (g*(x0+2x1+x2), a1*y1, a2*y2) through one shared multiplier that
// consumes four multiplicand bits per cycle of the 48-bit operand, top
// digit first, and each product is issued, accumulated and handed back;
// rounding, saturation and the history update follow in the wait and
// section states of each section, and the output mapping with its divide
// by 44 follows in the map states. The next sample is taken in the cycle
// after the result word leaves, so an output stall holds it off. While the
// enable register is clear and the block is idle, samples are taken and
// dropped at one per cycle. Slot numbers run from the base register and
// wrap around the 1024-slot ring.
module biquad_cascade_lowpass_to_drive #(
    parameter int STAGES     = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] drive_value,
    output logic [9:0]  slot
);
    `include "biquad_cascade_lowpass_to_drive_macros.svh"

    localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_SEC  = 3'd3;
    localparam logic [2:0] ST_MAP  = 3'd4;
    localparam logic [2:0] ST_MAP2 = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // configuration registers
    logic       enable_reg;
    logic [9:0] base_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            base_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bqcas_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                bqcas_pkg::REG_BASE:   base_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-section history (x1, x2, y1, y2)
    bqcas_pkg::sig_t x1_reg [STAGES];
    bqcas_pkg::sig_t x2_reg [STAGES];
    bqcas_pkg::sig_t y1_reg [STAGES];
    bqcas_pkg::sig_t y2_reg [STAGES];

    logic [2:0]      state_reg;
    logic [SW-1:0]   sec_reg;
    logic [1:0]      term_reg;
    logic            issued_reg;
    bqcas_pkg::sig_t v_reg;
    logic [bqcas_pkg::SLOT_W-1:0] cnt_reg;
    logic [15:0]     u_reg;
    logic [1:0]      wait_reg;

    bqcas_pkg::mac_ctl_t ctl;
    logic            mac_busy;
    bqcas_pkg::acc_t acc;
    bqcas_pkg::sig_t mcand;
    bqcas_pkg::coef_t cf;

    // current section's history through the selector
    bqcas_pkg::sig_t hx1, hx2, hy1, hy2;
    always_comb
    begin
        hx1 = x1_reg[sec_reg];
        hx2 = x2_reg[sec_reg];
        hy1 = y1_reg[sec_reg];
        hy2 = y2_reg[sec_reg];
        case (term_reg)
            2'd0:    mcand = v_reg + (hx1 <<< 1) + hx2;
            2'd1:    mcand = hy1;
            default: mcand = hy2;
        endcase
        cf = bqcas_pkg::coef(2'(sec_reg), term_reg);
    end

    // the section sum starts from zero for every section
    always_comb
    begin
        ctl.start = (state_reg == ST_MUL) && !issued_reg;
        ctl.clear = (state_reg == ST_IDLE) || (state_reg == ST_SEC);
    end

    bqcas_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .mcand  (mcand),
        .coef_in(cf),
        .busy   (mac_busy),
        .acc    (acc)
    );

    // rounding and saturation of the section sum
    logic [bqcas_pkg::ACC_W-1:0] rnd;
    logic signed [bqcas_pkg::ACC_W-31:0] ysh;
    bqcas_pkg::sig_t ysat;
    always_comb
    begin
        rnd = acc + bqcas_pkg::ACC_W'(64'd1 << 29);
        ysh = $signed(rnd[bqcas_pkg::ACC_W-1:30]);
        if (ysh > 54'sd1073741823)
            ysat = 48'sd1073741823;
        else if (ysh < -54'sd1073741824)
            ysat = -48'sd1073741824;
        else
            ysat = bqcas_pkg::sig_t'(ysh);
    end

    // output mapping: wrap then re-offset
    bqcas_pkg::sig_t t, tw;
    always_comb
    begin
        t  = v_reg + (48'sd32768 <<< 12);
        tw = (t > (48'sd65536 <<< 12)) ? t - (48'sd65536 <<< 12) : t;
    end
    bqcas_pkg::sig_t tu;
    assign tu = tw + (48'sd32768 <<< 12);

    logic [10:0] drv;
    bqcas_div44 u_div (
        .clk  (clk),
        .u    (u_reg),
        .drive(drv)
    );

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sec_reg     <= '0;
            term_reg    <= '0;
            issued_reg  <= 1'b0;
            v_reg       <= '0;
            u_reg       <= '0;
            cnt_reg     <= '0;
            out_valid   <= 1'b0;
            drive_value <= '0;
            slot        <= '0;
            wait_reg    <= '0;
            for (int i = 0; i < STAGES; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (in_valid && enable_reg)
                    begin
                        v_reg      <= bqcas_pkg::sig_t'({sample ^ 16'h8000, 12'd0});
                        sec_reg    <= '0;
                        term_reg   <= '0;
                        issued_reg <= 1'b0;
                        state_reg  <= ST_MUL;
                    end
                ST_MUL:
                    if (!issued_reg)
                        issued_reg <= 1'b1;
                    else if (!mac_busy)
                    begin
                        issued_reg <= 1'b0;
                        if (term_reg == 2'd2)
                            state_reg <= ST_WAIT;
                        else
                            term_reg <= term_reg + 2'd1;
                    end
                ST_WAIT:
                    state_reg <= ST_SEC;
                ST_SEC:
                begin
                    x2_reg[sec_reg] <= hx1;
                    x1_reg[sec_reg] <= v_reg;
                    y2_reg[sec_reg] <= hy1;
                    y1_reg[sec_reg] <= ysat;
                    v_reg    <= ysat;
                    term_reg <= '0;
                    if (sec_reg == SW'(STAGES - 1))
                        state_reg <= ST_MAP;
                    else
                    begin
                        sec_reg   <= sec_reg + SW'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_MAP:
                begin
                    u_reg     <= tu[27:12];
                    wait_reg  <= 2'd2;
                    state_reg <= ST_MAP2;
                end
                ST_MAP2:
                    if (wait_reg == 2'd0)
                    begin
                        drive_value <= drv;
                        // ten-bit sum wraps around the ring by itself
                        slot      <= base_reg + cnt_reg;
                        out_valid <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                        wait_reg <= wait_reg - 2'd1;
                ST_OUT:
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        cnt_reg   <= cnt_reg + 10'd1;
                        state_reg <= ST_IDLE;
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // result only shown in the output state
    `BQ_ASSERT_IMP(a_out_state, out_valid, state_reg == ST_OUT)
    // input never taken while work is pending
    `BQ_ASSERT_IMP(a_idle_in, in_ready, !out_valid)
    // delivered word returns the block to idle
    `BQ_ASSERT_NEXT(a_back_idle, out_valid && out_ready, state_reg == ST_IDLE)
endmodule
